FILE: design/thp_pkg.sv
// shared types, constants and helpers for the sensor trim compensation block
// no dependencies
package thp_pkg;

   localparam int DIV_STAGES = 32;

   typedef enum logic [2:0] {
      CSR_TEMP_TRIM       = 3'd0,
      CSR_PRESS_TRIM_LOW  = 3'd1,
      CSR_PRESS_TRIM_HIGH = 3'd2,
      CSR_PRESS_HUM_TRIM  = 3'd3,
      CSR_HUM_TRIM        = 3'd4
   } csr_index_type;

   localparam logic [31:0] K_64000   = 32'd64000;
   localparam logic [31:0] K_1048576 = 32'd1048576;
   localparam logic [31:0] K_3125    = 32'd3125;
   localparam logic [31:0] K_SIGN    = 32'h8000_0000;
   localparam logic [31:0] K_76800   = 32'd76800;
   localparam logic [31:0] K_HUM_MAX = 32'd419430400;
   localparam logic [31:0] K_2097152 = 32'd2097152;
   localparam logic [31:0] K_16384   = 32'd16384;
   localparam logic [31:0] K_32768   = 32'd32768;
   localparam logic [31:0] K_8192    = 32'd8192;
   localparam logic [31:0] K_5       = 32'd5;
   localparam logic [31:0] K_128     = 32'd128;

   // items that ride along with the divider
   typedef struct packed {
      logic [31:0] temp;
      logic [31:0] hum;
      logic        invalid;
      logic        twice;
   } side_type;

   function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] s);
      return $unsigned($signed(v) >>> s);
   endfunction

endpackage

FILE: design/thp_sensor_compensation.sv
// top level: temperature, pressure and humidity trim compensation pipeline
// depends on thp_pkg and thp_div
//
//  channel | dir | transaction contents
//  req_    | in  | tdata: raw_temperature, raw_pressure, raw_humidity
//  rsp_    | out | tdata: temperature_centi, pressure_pa, humidity_q10; tuser: invalid
//  csr_    | in  | one trim register write per cycle, index and 64-bit data
//
// one transaction per cycle while rsp_ is not stalled; the pipe is 12 arithmetic
// stages, 32 divider stages, 3 tail stages and the output register
// the 32-stage quotient pipeline sets the depth, every stage holds one multiply
// at most; synchronous active-high reset clears valid bits and trim registers
// a stalled rsp_ freezes the whole pipeline, nothing is lost or repeated
module thp_sensor_compensation import thp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // raw_temperature[19:0], raw_pressure[39:20], raw_humidity[55:40]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // temperature_centi[31:0], pressure_pa[63:32], humidity_q10[80:64]
   output logic        rsp_tuser,   // pressure_invalid
   input  logic        csr_wen,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   // trim registers
   logic [47:0] temp_trim_ff;
   logic [63:0] press_low_ff, press_high_ff;
   logic [47:0] press_hum_ff;
   logic [39:0] hum_trim_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff  <= '0;
         press_low_ff  <= '0;
         press_high_ff <= '0;
         press_hum_ff  <= '0;
         hum_trim_ff   <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_TEMP_TRIM:       temp_trim_ff  <= csr_wdata[47:0];
            CSR_PRESS_TRIM_LOW:  press_low_ff  <= csr_wdata;
            CSR_PRESS_TRIM_HIGH: press_high_ff <= csr_wdata;
            CSR_PRESS_HUM_TRIM:  press_hum_ff  <= csr_wdata[47:0];
            CSR_HUM_TRIM:        hum_trim_ff   <= csr_wdata[39:0];
            default: ; // writes beyond the list are dropped
         endcase
      end
   end

   // coefficient unpacking, all widened to 32 bits
   logic [31:0] tr_t1, tr_t2, tr_t3;
   logic [31:0] tr_p1, tr_p2, tr_p3, tr_p4, tr_p5, tr_p6, tr_p7, tr_p8, tr_p9;
   logic [31:0] tr_h1, tr_h2, tr_h3, tr_h4, tr_h5, tr_h6;

   assign tr_t1 = {16'b0, temp_trim_ff[15:0]};
   assign tr_t2 = {{16{temp_trim_ff[31]}}, temp_trim_ff[31:16]};
   assign tr_t3 = {{16{temp_trim_ff[47]}}, temp_trim_ff[47:32]};
   assign tr_p1 = {16'b0, press_low_ff[15:0]};
   assign tr_p2 = {{16{press_low_ff[31]}}, press_low_ff[31:16]};
   assign tr_p3 = {{16{press_low_ff[47]}}, press_low_ff[47:32]};
   assign tr_p4 = {{16{press_low_ff[63]}}, press_low_ff[63:48]};
   assign tr_p5 = {{16{press_high_ff[15]}}, press_high_ff[15:0]};
   assign tr_p6 = {{16{press_high_ff[31]}}, press_high_ff[31:16]};
   assign tr_p7 = {{16{press_high_ff[47]}}, press_high_ff[47:32]};
   assign tr_p8 = {{16{press_high_ff[63]}}, press_high_ff[63:48]};
   assign tr_p9 = {{16{press_hum_ff[15]}}, press_hum_ff[15:0]};
   assign tr_h1 = {24'b0, press_hum_ff[23:16]};
   assign tr_h2 = {{16{press_hum_ff[39]}}, press_hum_ff[39:24]};
   assign tr_h3 = {24'b0, press_hum_ff[47:40]};
   assign tr_h4 = {{16{hum_trim_ff[15]}}, hum_trim_ff[15:0]};
   assign tr_h5 = {{16{hum_trim_ff[31]}}, hum_trim_ff[31:16]};
   assign tr_h6 = {{24{hum_trim_ff[39]}}, hum_trim_ff[39:32]};

   // global advance: the pipe moves whenever the output register can take data
   logic rsp_valid_ff;
   logic advance;
   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;

   logic [19:0] raw_t, raw_p;
   logic [15:0] raw_h;
   assign raw_t = req_tdata[19:0];
   assign raw_p = req_tdata[39:20];
   assign raw_h = req_tdata[55:40];

   logic [12:1] v_ff;

   // stage registers
   logic [31:0] s1_ta_ff, s1_td_ff;
   logic [19:0] s1_rp_ff, s2_rp_ff, s3_rp_ff, s4_rp_ff, s5_rp_ff, s6_rp_ff;
   logic [19:0] s7_rp_ff, s8_rp_ff, s9_rp_ff;
   logic [15:0] s1_rh_ff, s2_rh_ff, s3_rh_ff, s4_rh_ff, s5_rh_ff, s6_rh_ff;
   logic [31:0] s2_m1_ff, s2_m2_ff;
   logic [31:0] s3_a_ff, s3_m3_ff;
   logic [31:0] s4_fine_ff;
   logic [31:0] s5_tm_ff, s5_pa_ff, s5_pd_ff, s5_ha_ff;
   logic [31:0] s6_temp_ff, s6_dd_ff, s6_ap5_ff, s6_p2a_ff, s6_hm5_ff, s6_ah6_ff, s6_ah3_ff;
   logic [31:0] s7_temp_ff, s7_b1_ff, s7_p3d_ff, s7_ap5_ff, s7_p2a_ff;
   logic [31:0] s7_hb_ff, s7_hx_ff, s7_hy_ff;
   logic [31:0] s8_temp_ff, s8_b_ff, s8_a_ff, s8_hz_ff, s8_hb_ff;
   logic [31:0] s9_temp_ff, s9_am_ff, s9_b_ff, s9_hd_ff, s9_hb_ff;
   logic [31:0] s10_temp_ff, s10_div_ff, s10_pn1_ff, s10_hd2_ff, s10_hb_ff;
   logic [31:0] s11_temp_ff, s11_div_ff, s11_pn_ff, s11_hd3_ff, s11_hb_ff;
   logic [31:0] s12_div_ff, s12_dvd_ff;
   side_type    s12_side_ff;

   // combinational helpers
   logic [31:0] s5_pa_in, s8_sum_in, s9_a32_in;
   logic        s11_big_in;

   assign s5_pa_in   = asr32(s4_fine_ff, 5'd1) - K_64000;
   assign s8_sum_in  = asr32(s7_p3d_ff, 5'd3) + asr32(s7_p2a_ff, 5'd1);
   assign s9_a32_in  = K_32768 + s8_a_ff;
   assign s11_big_in = (s11_pn_ff >= K_SIGN);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[11:1], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         // temperature differences
         s1_ta_ff <= {15'b0, raw_t[19:3]} - {tr_t1[30:0], 1'b0};
         s1_td_ff <= {16'b0, raw_t[19:4]} - tr_t1;
         s1_rp_ff <= raw_p;
         s1_rh_ff <= raw_h;
         // temperature products
         s2_m1_ff <= s1_ta_ff * tr_t2;
         s2_m2_ff <= s1_td_ff * s1_td_ff;
         s2_rp_ff <= s1_rp_ff;
         s2_rh_ff <= s1_rh_ff;
         s3_a_ff  <= asr32(s2_m1_ff, 5'd11);
         s3_m3_ff <= asr32(s2_m2_ff, 5'd12) * tr_t3;
         s3_rp_ff <= s2_rp_ff;
         s3_rh_ff <= s2_rh_ff;
         // fine temperature
         s4_fine_ff <= s3_a_ff + asr32(s3_m3_ff, 5'd14);
         s4_rp_ff   <= s3_rp_ff;
         s4_rh_ff   <= s3_rh_ff;
         // fine fans out to all three results
         s5_tm_ff <= s4_fine_ff * K_5;
         s5_pa_ff <= s5_pa_in;
         s5_pd_ff <= asr32(s5_pa_in, 5'd2);
         s5_ha_ff <= s4_fine_ff - K_76800;
         s5_rp_ff <= s4_rp_ff;
         s5_rh_ff <= s4_rh_ff;
         // first product layer
         s6_temp_ff <= asr32(s5_tm_ff + K_128, 5'd8);
         s6_dd_ff   <= s5_pd_ff * s5_pd_ff;
         s6_ap5_ff  <= s5_pa_ff * tr_p5;
         s6_p2a_ff  <= tr_p2 * s5_pa_ff;
         s6_hm5_ff  <= tr_h5 * s5_ha_ff;
         s6_ah6_ff  <= s5_ha_ff * tr_h6;
         s6_ah3_ff  <= s5_ha_ff * tr_h3;
         s6_rp_ff   <= s5_rp_ff;
         s6_rh_ff   <= s5_rh_ff;
         // second product layer
         s7_temp_ff <= s6_temp_ff;
         s7_b1_ff   <= asr32(s6_dd_ff, 5'd11) * tr_p6;
         s7_p3d_ff  <= tr_p3 * asr32(s6_dd_ff, 5'd13);
         s7_ap5_ff  <= s6_ap5_ff;
         s7_p2a_ff  <= s6_p2a_ff;
         s7_hb_ff   <= asr32({2'b0, s6_rh_ff, 14'b0} - {tr_h4[11:0], 20'b0}
                             - s6_hm5_ff + K_16384, 5'd15);
         s7_hx_ff   <= asr32(s6_ah6_ff, 5'd10);
         s7_hy_ff   <= asr32(s6_ah3_ff, 5'd11) + K_32768;
         s7_rp_ff   <= s6_rp_ff;
         // pressure offset terms and humidity scale
         s8_temp_ff <= s7_temp_ff;
         s8_b_ff    <= asr32(s7_b1_ff + {s7_ap5_ff[30:0], 1'b0}, 5'd2)
                       + {tr_p4[15:0], 16'b0};
         s8_a_ff    <= asr32(s8_sum_in, 5'd18);
         s8_hz_ff   <= s7_hx_ff * s7_hy_ff;
         s8_hb_ff   <= s7_hb_ff;
         s8_rp_ff   <= s7_rp_ff;
         s9_temp_ff <= s8_temp_ff;
         s9_am_ff   <= s9_a32_in * tr_p1;
         s9_b_ff    <= s8_b_ff;
         s9_hd_ff   <= asr32(s8_hz_ff, 5'd10) + K_2097152;
         s9_hb_ff   <= s8_hb_ff;
         s9_rp_ff   <= s8_rp_ff;
         // divisor and numerator base
         s10_temp_ff <= s9_temp_ff;
         s10_div_ff  <= asr32(s9_am_ff, 5'd15);
         s10_pn1_ff  <= (K_1048576 - {12'b0, s9_rp_ff}) - asr32(s9_b_ff, 5'd12);
         s10_hd2_ff  <= s9_hd_ff * tr_h2;
         s10_hb_ff   <= s9_hb_ff;
         s11_temp_ff <= s10_temp_ff;
         s11_div_ff  <= s10_div_ff;
         s11_pn_ff   <= s10_pn1_ff * K_3125;
         s11_hd3_ff  <= asr32(s10_hd2_ff + K_8192, 5'd14);
         s11_hb_ff   <= s10_hb_ff;
         // dividend select: doubled before the divide unless the top bit is set
         s12_div_ff          <= s11_div_ff;
         s12_dvd_ff          <= s11_big_in ? s11_pn_ff : {s11_pn_ff[30:0], 1'b0};
         s12_side_ff.temp    <= s11_temp_ff;
         s12_side_ff.hum     <= s11_hb_ff * s11_hd3_ff;
         s12_side_ff.invalid <= (s11_div_ff == '0);
         s12_side_ff.twice   <= s11_big_in;
      end
   end

   // quotient pipeline
   logic        dv_valid;
   logic [31:0] dv_quot;
   side_type    dv_side;

   thp_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (advance),
      .in_valid  (v_ff[12]),
      .dividend  (s12_dvd_ff),
      .divisor   (s12_div_ff),
      .in_side   (s12_side_ff),
      .out_valid (dv_valid),
      .quotient  (dv_quot),
      .out_side  (dv_side)
   );

   // tail stages
   logic        q1_valid_ff, q2_valid_ff, q3_valid_ff;
   logic [31:0] q1_p_ff, q1_hsq_ff, q1_h_ff, q1_temp_ff;
   logic        q1_inv_ff, q2_inv_ff, q3_inv_ff;
   logic [31:0] q2_p_ff, q2_pm1_ff, q2_pm2_ff, q2_hm_ff, q2_h_ff, q2_temp_ff;
   logic [31:0] q3_p_ff, q3_pa_ff, q3_pb_ff, q3_temp_ff;
   logic [16:0] q3_hum_ff;
   logic [31:0] rsp_temp_ff, rsp_press_ff;
   logic [16:0] rsp_hum_ff;
   logic        rsp_inv_ff;

   logic [31:0] hs_in, p3_in, p4_in, hfin_in, hclamp_in, press_in;

   assign hs_in     = asr32(dv_side.hum, 5'd15);
   assign p3_in     = {3'b0, q1_p_ff[31:3]};
   assign p4_in     = {2'b0, q1_p_ff[31:2]};
   assign hfin_in   = q2_h_ff - asr32(q2_hm_ff, 5'd4);
   assign press_in  = q3_p_ff + asr32(asr32(q3_pa_ff, 5'd12) + q3_pb_ff + tr_p7, 5'd4);

   // humidity clamp to 0..100 percent
   always_comb begin
      priority if (hfin_in[31]) begin
         hclamp_in = '0;
      end else if (hfin_in > K_HUM_MAX) begin
         hclamp_in = K_HUM_MAX;
      end else begin
         hclamp_in = hfin_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q1_valid_ff  <= 1'b0;
         q2_valid_ff  <= 1'b0;
         q3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         q1_valid_ff  <= dv_valid;
         q2_valid_ff  <= q1_valid_ff;
         q3_valid_ff  <= q2_valid_ff;
         rsp_valid_ff <= q3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         q1_p_ff    <= dv_side.twice ? {dv_quot[30:0], 1'b0} : dv_quot;
         q1_hsq_ff  <= hs_in * hs_in;
         q1_h_ff    <= dv_side.hum;
         q1_temp_ff <= dv_side.temp;
         q1_inv_ff  <= dv_side.invalid;
         // pressure correction products
         q2_p_ff    <= q1_p_ff;
         q2_pm1_ff  <= p3_in * p3_in;
         q2_pm2_ff  <= p4_in * tr_p8;
         q2_hm_ff   <= asr32(q1_hsq_ff, 5'd7) * tr_h1;
         q2_h_ff    <= q1_h_ff;
         q2_temp_ff <= q1_temp_ff;
         q2_inv_ff  <= q1_inv_ff;
         q3_p_ff    <= q2_p_ff;
         q3_pa_ff   <= tr_p9 * {13'b0, q2_pm1_ff[31:13]};
         q3_pb_ff   <= asr32(q2_pm2_ff, 5'd13);
         q3_hum_ff  <= hclamp_in[28:12];
         q3_temp_ff <= q2_temp_ff;
         q3_inv_ff  <= q2_inv_ff;
         // output register
         rsp_temp_ff  <= q3_temp_ff;
         rsp_press_ff <= q3_inv_ff ? '0 : press_in;
         rsp_hum_ff   <= q3_hum_ff;
         rsp_inv_ff   <= q3_inv_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_hum_ff, rsp_press_ff, rsp_temp_ff};
   assign rsp_tuser  = rsp_inv_ff;

   // zero divisor always reports zero pressure
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[63:32] == '0)
      else $error("invalid pressure not zero");

   // humidity never exceeds 100 percent
   a_hum_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[80:64] <= 17'd102400)
      else $error("humidity out of range");

   // a stalled result holds its pipeline: the tail does not advance
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(q3_valid_ff) && $stable(rsp_tdata))
      else $error("pipeline moved under stall");

   // nothing comes out right after reset
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

FILE: design/thp_div.sv
// pipelined restoring unsigned divider, one quotient bit per stage
// depends on thp_pkg
module thp_div import thp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [31:0] quotient,
   output side_type    out_side
);

   logic [31:0] rem_ff  [DIV_STAGES];
   logic [31:0] work_ff [DIV_STAGES];
   logic [31:0] dvs_ff  [DIV_STAGES];
   side_type    side_ff [DIV_STAGES];
   logic        vld_ff  [DIV_STAGES];

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      logic [31:0] rem_prev, work_prev, dvs_prev;
      side_type    side_prev;
      logic        vld_prev;
      logic [32:0] trial;
      logic [32:0] diff;
      logic        qbit;
      logic [31:0] rem_in, work_in;

      if (k == 0) begin : g_first
         assign rem_prev  = '0;
         assign work_prev = dividend;
         assign dvs_prev  = divisor;
         assign side_prev = in_side;
         assign vld_prev  = in_valid;
      end else begin : g_next
         assign rem_prev  = rem_ff[k-1];
         assign work_prev = work_ff[k-1];
         assign dvs_prev  = dvs_ff[k-1];
         assign side_prev = side_ff[k-1];
         assign vld_prev  = vld_ff[k-1];
      end

      always_comb begin
         trial   = {rem_prev, work_prev[31]};
         diff    = trial - {1'b0, dvs_prev};
         qbit    = (trial >= {1'b0, dvs_prev});
         rem_in  = qbit ? diff[31:0] : trial[31:0];
         work_in = {work_prev[30:0], qbit};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (en) begin
            vld_ff[k] <= vld_prev;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            work_ff[k] <= work_in;
            dvs_ff[k]  <= dvs_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = vld_ff[DIV_STAGES-1];
   assign quotient  = work_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

endmodule
